### hdl/zcgd_pkg.sv
// Shared types, constants and code tables for the zero count group decoder.
package zcgd_pkg;

    localparam int ZcW       = 16;
    localparam int ResW      = 8;
    localparam int BudgetW   = 20;
    localparam int MaxRes    = 4;
    localparam int CntW      = 3;
    localparam int IdxW      = 2;
    localparam int CfgIdxW   = 2;
    localparam int CfgDataW  = 20;

    localparam logic [BudgetW-1:0] UsedMax = {BudgetW{1'b1}};

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_TARGET_ZEROS   = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_RESIDUAL_COUNT = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_BIT_BUDGET     = 2'd2;

    // Result lengths
    localparam logic [1:0] LEN_MARKER = 2'd0;
    localparam logic [1:0] LEN_RAW    = 2'd1;
    localparam logic [1:0] LEN_GROUP  = 2'd3;

    typedef enum logic [1:0] {
        PH_GROUP = 2'd0,
        PH_RAW   = 2'd1
    } phase_t;

    typedef struct packed {
        logic [2:0] val;
        logic [1:0] len;
        logic       last;
        logic [2:0] unc;
    } res_t;

    // Up to four results caused by one item, oldest in item[0]
    typedef struct packed {
        res_t [MaxRes-1:0] item;
        logic [CntW-1:0]   cnt;
    } bundle_t;

    // Map a complete prefix code to its 3-bit group
    function automatic logic [2:0] group_of(logic [3:0] code, logic [2:0] code_len);
        logic [2:0] grp;
        grp = 3'd0;
        if (code_len == 3'd4) begin
            grp = code[0] ? 3'd7 : 3'd5;
        end else if (code_len == 3'd3) begin
            unique case (code[2:0])
                3'd2:    grp = 3'd1;
                3'd3:    grp = 3'd2;
                3'd4:    grp = 3'd4;
                3'd5:    grp = 3'd6;
                default: grp = 3'd3;
            endcase
        end
        return grp;
    endfunction

endpackage

### hdl/zcgd_decode.sv
// Prefix decoder with zero counting, raw tail handling and block restart.
module zcgd_decode (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                accept,
    input  logic                                code_bit,
    input  logic [zcgd_pkg::ZcW-1:0]            target_zeros,
    input  logic [zcgd_pkg::ResW-1:0]           residual_count,
    input  logic [zcgd_pkg::BudgetW-1:0]        bit_budget,
    output zcgd_pkg::bundle_t                   bundle
);

    typedef struct packed {
        zcgd_pkg::bundle_t          b;
        logic [zcgd_pkg::ZcW-1:0]   zc;
        logic                       fin;
    } raw_res_t;

    logic [zcgd_pkg::ZcW-1:0]     zc_reg, zc_next;
    logic [zcgd_pkg::BudgetW-1:0] bu_reg, bu_next;
    logic [3:0]                   cb_reg, cb_next;
    logic [2:0]                   cl_reg, cl_next;
    zcgd_pkg::phase_t             ph_reg, ph_next;

    logic [zcgd_pkg::BudgetW-1:0] bu_inc;
    logic [3:0]                   cb_new;
    logic [2:0]                   cl_new;
    logic                         done;
    logic [2:0]                   grp;
    logic [1:0]                   z;
    logic [zcgd_pkg::ZcW:0]       over_sum;
    logic [zcgd_pkg::ZcW-1:0]     zc_sum;
    logic                         ms_cur, ms_new;
    logic                         use_raw, restart;
    logic [3:0]                   rf_buf;
    logic [2:0]                   rf_len;
    raw_res_t                     rf;

    function automatic logic may_start(logic [15:0] zc, logic [19:0] bu, logic [15:0] tgt,
                                       logic [7:0] res, logic [19:0] budget);
        logic [16:0] zr;
        logic [20:0] br;
        zr = 17'(zc) + 17'(res);
        br = 21'(bu) + 21'(res) + 21'd2;
        return (zr <= 17'(tgt)) && (zc < tgt) && (br <= 21'(budget));
    endfunction

    // Emit len bits of buf_in raw, oldest first, until the zero target is met
    function automatic raw_res_t raw_feed(logic [3:0] buf_in, logic [2:0] len,
                                          logic [15:0] zc, logic [15:0] tgt);
        raw_res_t    r;
        logic [3:0]  al;
        logic [15:0] gap;
        logic [2:0]  zeros;
        logic        stop;
        logic        b;
        r     = '0;
        r.zc  = zc;
        al    = '0;
        gap   = '0;
        zeros = '0;
        stop  = 1'b0;
        b     = 1'b0;
        if (zc >= tgt) begin
            r.b.item[0].last = 1'b1;
            r.b.item[0].len  = zcgd_pkg::LEN_MARKER;
            r.b.item[0].unc  = len;
            r.b.cnt          = 3'd1;
            r.fin            = 1'b1;
        end else begin
            gap = tgt - zc;
            al  = buf_in << (3'd4 - len);
            for (int i = 0; i < zcgd_pkg::MaxRes; i++) begin
                if (!stop && (3'(i) < len)) begin
                    b     = al[3-i];
                    zeros = zeros + {2'b00, ~b};
                    r.b.item[i].val = {2'b00, b};
                    r.b.item[i].len = zcgd_pkg::LEN_RAW;
                    if (16'(zeros) >= gap) begin
                        r.b.item[i].last = 1'b1;
                        r.b.item[i].unc  = len - 3'(i) - 3'd1;
                        stop  = 1'b1;
                        r.fin = 1'b1;
                    end
                    r.b.cnt = 3'(i + 1);
                end
            end
            r.zc = zc + 16'(zeros);
        end
        return r;
    endfunction

    assign bu_inc = (bu_reg == zcgd_pkg::UsedMax) ? bu_reg : bu_reg + 20'd1;
    assign cb_new = {cb_reg[2:0], code_bit};
    assign cl_new = cl_reg + 3'd1;
    assign grp    = zcgd_pkg::group_of(cb_new, cl_new);
    assign z      = 2'(3'd3 - (3'(grp[0]) + 3'(grp[1]) + 3'(grp[2])));
    assign over_sum = 17'(zc_reg) + 17'(z) + 17'(residual_count);
    assign zc_sum = zc_reg + 16'(z);
    assign ms_cur = may_start(zc_reg, bu_reg, target_zeros, residual_count, bit_budget);
    assign ms_new = may_start(zc_sum, bu_inc, target_zeros, residual_count, bit_budget);
    assign rf     = raw_feed(rf_buf, rf_len, zc_reg, target_zeros);

    always_comb begin
        unique case (cl_new)
            3'd2:    done = (cb_new[1:0] == 2'b00);
            3'd3:    done = (cb_new[2:0] != 3'b111);
            3'd4:    done = 1'b1;
            default: done = 1'b0;
        endcase
    end

    always_comb begin
        zc_next = zc_reg;
        bu_next = bu_reg;
        cb_next = cb_reg;
        cl_next = cl_reg;
        ph_next = ph_reg;
        bundle  = '0;
        use_raw = 1'b0;
        restart = 1'b0;
        rf_buf  = {3'b000, code_bit};
        rf_len  = 3'd1;

        unique case (ph_reg)
            zcgd_pkg::PH_RAW: begin
                bu_next = bu_inc;
                use_raw = 1'b1;
            end
            zcgd_pkg::PH_GROUP: begin
                if (cl_reg == 3'd0 && bu_reg == '0 && !ms_cur) begin
                    // block start with no room for a group
                    if (residual_count == '0) begin
                        bundle.item[0].last = 1'b1;
                        bundle.item[0].unc  = 3'd1;
                        bundle.cnt          = 3'd1;
                        restart             = 1'b1;
                    end else begin
                        bu_next = 20'd1;
                        use_raw = 1'b1;
                    end
                end else begin
                    bu_next = bu_inc;
                    if (!done) begin
                        cb_next = cb_new;
                        cl_next = cl_new;
                    end else begin
                        cb_next = '0;
                        cl_next = '0;
                        bundle.item[0].val = grp;
                        bundle.item[0].len = zcgd_pkg::LEN_GROUP;
                        bundle.cnt         = 3'd1;
                        if (over_sum > 17'(target_zeros)) begin
                            // overshooting group: hand back or pass raw
                            if (residual_count == '0) begin
                                bundle              = '0;
                                bundle.item[0].last = 1'b1;
                                bundle.item[0].unc  = cl_new;
                                bundle.cnt          = 3'd1;
                                restart             = 1'b1;
                            end else begin
                                use_raw = 1'b1;
                                rf_buf  = cb_new;
                                rf_len  = cl_new;
                            end
                        end else begin
                            zc_next = zc_sum;
                            if (!ms_new) begin
                                if (residual_count == '0 || zc_sum >= target_zeros) begin
                                    bundle.item[0].last = 1'b1;
                                    restart             = 1'b1;
                                end else begin
                                    ph_next = zcgd_pkg::PH_RAW;
                                end
                            end
                        end
                    end
                end
            end
            default: begin
                restart = 1'b1;
            end
        endcase

        if (use_raw) begin
            bundle  = rf.b;
            ph_next = zcgd_pkg::PH_RAW;
            zc_next = rf.zc;
            restart = rf.fin;
        end

        if (restart) begin
            zc_next = '0;
            bu_next = '0;
            cb_next = '0;
            cl_next = '0;
            ph_next = zcgd_pkg::PH_GROUP;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zc_reg <= '0;
            bu_reg <= '0;
            cb_reg <= '0;
            cl_reg <= '0;
            ph_reg <= zcgd_pkg::PH_GROUP;
        end else if (accept) begin
            zc_reg <= zc_next;
            bu_reg <= bu_next;
            cb_reg <= cb_next;
            cl_reg <= cl_next;
            ph_reg <= ph_next;
        end
    end

endmodule

### hdl/zcgd_outq.sv
// Result register holding one item's results and handing them out one per cycle while m_ready is high.
module zcgd_outq (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  zcgd_pkg::bundle_t bundle,
    output logic              room,
    output logic              m_valid,
    input  logic              m_ready,
    output zcgd_pkg::res_t    m_res
);

    zcgd_pkg::bundle_t              bundle_reg;
    logic [zcgd_pkg::CntW-1:0]      left_reg, left_next;
    logic [zcgd_pkg::IdxW-1:0]      idx_reg, idx_next;
    logic                           pop;

    assign m_valid = (left_reg != '0);
    assign pop     = m_valid && m_ready;
    assign m_res   = bundle_reg.item[idx_reg];
    // free next cycle: empty, or last result leaving now
    assign room    = (left_reg == '0) || (left_reg == 3'd1 && m_ready);

    always_comb begin
        left_next = left_reg;
        idx_next  = idx_reg;
        if (load) begin
            left_next = bundle.cnt;
            idx_next  = '0;
        end else if (pop) begin
            left_next = left_reg - 3'd1;
            idx_next  = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg <= '0;
            idx_reg  <= '0;
        end else begin
            left_reg <= left_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            bundle_reg <= bundle;
        end
    end

    a_left_range: assert property (@(posedge aclk) disable iff (!aresetn)
        left_reg <= 3'(zcgd_pkg::MaxRes))
        else $error("result count out of range");

    a_idx_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (3'(idx_reg) + left_reg <= 3'(zcgd_pkg::MaxRes)))
        else $error("result index past end of stored results");

    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && bundle.cnt != '0) |=> m_valid)
        else $error("loaded results not presented");

    a_last_final: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_res.last) |-> (left_reg == 3'd1))
        else $error("block end flagged before final stored result");

endmodule

### hdl/zero_count_group_decoder_top.sv
// Top level of the zero count group decoder: ports, configuration registers, wiring.
//
// Usage:
//   Input channel (s_valid/s_ready/s_code_bit) takes one code bit per item,
//   oldest bit of the stream first. Result channel (m_valid/m_ready) delivers
//   decoded 3-bit groups (m_sym_len = 3), raw tail bits (m_sym_len = 1) or an
//   end marker (m_sym_len = 0). m_last marks the final result of a block and
//   m_unconsumed_bits counts the trailing input bits that belong to the next
//   consumer; the next bit accepted starts a new block.
//   Configuration (cfg_valid/cfg_ready/cfg_index/cfg_data) writes target_zeros
//   (index 0), residual_count (index 1) and bit_budget (index 2); write only
//   while no results are outstanding. cfg_ready is always high.
// Timing:
//   Results of an item appear on the cycle after it is accepted. Items that
//   cause zero or one result let bits stream at one per cycle while m_ready
//   stays high; an item that releases k buffered raw bits (k up to 4) holds
//   the input until the single result port has drained the result register.
// Reset: aresetn low clears the decoder state, the configuration and any
//   pending results. Stall: while m_ready is low the current result holds and
//   s_ready drops once the result register cannot be freed in the next cycle.
module zero_count_group_decoder_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_code_bit,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [2:0]                          m_sym_value,
    output logic [1:0]                          m_sym_len,
    output logic                                m_last,
    output logic [2:0]                          m_unconsumed_bits,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [zcgd_pkg::CfgIdxW-1:0]        cfg_index,
    input  logic [zcgd_pkg::CfgDataW-1:0]       cfg_data
);

    logic [zcgd_pkg::ZcW-1:0]     target_zeros_reg;
    logic [zcgd_pkg::ResW-1:0]    residual_count_reg;
    logic [zcgd_pkg::BudgetW-1:0] bit_budget_reg;

    logic              s_accept;
    zcgd_pkg::bundle_t bundle;
    zcgd_pkg::res_t    m_res;

    assign cfg_ready = 1'b1;
    assign s_accept  = s_valid && s_ready;

    // Hold configuration; indexes beyond the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_zeros_reg   <= '0;
            residual_count_reg <= '0;
            bit_budget_reg     <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                zcgd_pkg::CFG_TARGET_ZEROS:   target_zeros_reg   <= cfg_data[15:0];
                zcgd_pkg::CFG_RESIDUAL_COUNT: residual_count_reg <= cfg_data[7:0];
                zcgd_pkg::CFG_BIT_BUDGET:     bit_budget_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // Decode the accepted bit into this item's results
    zcgd_decode u_decode (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .accept         (s_accept),
        .code_bit       (s_code_bit),
        .target_zeros   (target_zeros_reg),
        .residual_count (residual_count_reg),
        .bit_budget     (bit_budget_reg),
        .bundle         (bundle)
    );

    // Store the results and hand them out one per cycle while m_ready is high
    zcgd_outq u_outq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (s_accept),
        .bundle  (bundle),
        .room    (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_res   (m_res)
    );

    assign m_sym_value       = m_res.val;
    assign m_sym_len         = m_res.len;
    assign m_last            = m_res.last;
    assign m_unconsumed_bits = m_res.unc;

endmodule

### dv/tb_top.sv
// Self-checking testbench for the zero count group decoder: random code bits, prediction, result check.
`timescale 1ns / 100ps

module tb_top;

    // Clock, reset and the block's ports; every input starts at a known value
    logic                          aclk              = 1'b0;
    logic                          aresetn           = 1'b0;
    logic                          s_valid           = 1'b0;
    logic                          s_ready;
    logic                          s_code_bit        = 1'b0;
    logic                          m_valid;
    logic                          m_ready           = 1'b0;
    logic [2:0]                    m_sym_value;
    logic [1:0]                    m_sym_len;
    logic                          m_last;
    logic [2:0]                    m_unconsumed_bits;
    logic                          cfg_valid         = 1'b0;
    logic                          cfg_ready;
    logic [zcgd_pkg::CfgIdxW-1:0]  cfg_index         = '0;
    logic [zcgd_pkg::CfgDataW-1:0] cfg_data          = '0;

    zero_count_group_decoder_top DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_code_bit        (s_code_bit),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_sym_value       (m_sym_value),
        .m_sym_len         (m_sym_len),
        .m_last            (m_last),
        .m_unconsumed_bits (m_unconsumed_bits),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    localparam int unsigned CycleLimit = 200000;

    // Stimulus and bookkeeping
    logic             code_bits_q[$];     // code bits still to be offered, oldest first
    zcgd_pkg::res_t   expected_syms[$];   // predicted results, oldest first
    bit               bit_taken;          // the item on s_ channel was accepted at the last edge
    bit               calm;               // no idling on either side
    int unsigned      bits_accepted;
    int unsigned      mismatches;
    int unsigned      cycles;
    int unsigned      src_gap;
    int unsigned      sink_gap;
    int unsigned      hold_cycles;
    bit               long_hold_done;

    // Shadow of the configuration registers
    logic [15:0] tgt_zeros;
    logic [7:0]  resid_zeros;
    logic [19:0] budget_bits;

    // Shadow of the decoder state
    int unsigned       zeros_seen;
    int unsigned       bits_seen;
    logic [3:0]        code_sr;
    logic [2:0]        code_n;
    zcgd_pkg::phase_t  dec_phase;

    initial begin
        forever #6 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Decoder prediction
    // ------------------------------------------------------------------
    task automatic push_sym(input logic [2:0] val, input logic [1:0] len,
                            input logic lst, input logic [2:0] unc);
        zcgd_pkg::res_t r;
        r.val  = val;
        r.len  = len;
        r.last = lst;
        r.unc  = unc;
        expected_syms.push_back(r);
    endtask

    task automatic restart_block();
        zeros_seen = 0;
        bits_seen  = 0;
        code_sr    = '0;
        code_n     = '0;
        dec_phase  = zcgd_pkg::PH_GROUP;
    endtask

    // A new group may open only while zeros and budget leave room for it
    function automatic bit group_may_open();
        return (zeros_seen + resid_zeros <= tgt_zeros) && (zeros_seen < tgt_zeros) &&
               (bits_seen + resid_zeros + 2 <= budget_bits);
    endfunction

    // Pass n buffered bits (oldest in the highest position) through raw
    task automatic emit_raw(input logic [3:0] bufv, input int unsigned n);
        int unsigned i;
        logic        b;
        dec_phase = zcgd_pkg::PH_RAW;
        if (zeros_seen >= tgt_zeros) begin
            push_sym(3'd0, zcgd_pkg::LEN_MARKER, 1'b1, n[2:0]);
            restart_block();
            return;
        end
        for (i = 0; i < n; i++) begin
            b = bufv[n - 1 - i];
            if (!b)
                zeros_seen++;
            if (zeros_seen >= tgt_zeros) begin
                push_sym({2'b00, b}, zcgd_pkg::LEN_RAW, 1'b1, 3'(n - 1 - i));
                restart_block();
                return;
            end
            push_sym({2'b00, b}, zcgd_pkg::LEN_RAW, 1'b0, 3'd0);
        end
    endtask

    task automatic decode_code_bit(input logic b);
        logic [2:0]  grp;
        int unsigned z;
        bit          done;
        logic [3:0]  bufv;
        int unsigned n;
        if (dec_phase == zcgd_pkg::PH_RAW) begin
            if (bits_seen < zcgd_pkg::UsedMax)
                bits_seen++;
            emit_raw({3'b000, b}, 1);
            return;
        end
        // No room for a group at block start
        if (code_n == 0 && bits_seen == 0 && !group_may_open()) begin
            if (resid_zeros == 0) begin
                push_sym(3'd0, zcgd_pkg::LEN_MARKER, 1'b1, 3'd1);
                restart_block();
                return;
            end
            bits_seen = 1;
            emit_raw({3'b000, b}, 1);
            return;
        end
        if (bits_seen < zcgd_pkg::UsedMax)
            bits_seen++;
        code_sr = {code_sr[2:0], b};
        code_n  = code_n + 3'd1;
        if (code_n <= 1)
            return;
        case (code_n)
            3'd2:    done = (code_sr == 4'd0);
            3'd3:    done = (code_sr != 4'd7);
            default: done = 1'b1;
        endcase
        if (!done)
            return;
        if (code_n == 3'd2) begin
            grp = 3'd0;
        end else if (code_n == 3'd3) begin
            case (code_sr[2:0])
                3'd2:    grp = 3'd1;
                3'd3:    grp = 3'd2;
                3'd4:    grp = 3'd4;
                3'd5:    grp = 3'd6;
                default: grp = 3'd3;
            endcase
        end else begin
            grp = code_sr[0] ? 3'd7 : 3'd5;
        end
        z = 3 - $countones(grp);
        // Overshooting group: drop it, or send its bits raw
        if (zeros_seen + z + resid_zeros > tgt_zeros) begin
            bufv    = code_sr;
            n       = code_n;
            code_sr = '0;
            code_n  = '0;
            if (resid_zeros == 0) begin
                push_sym(3'd0, zcgd_pkg::LEN_MARKER, 1'b1, n[2:0]);
                restart_block();
                return;
            end
            emit_raw(bufv, n);
            return;
        end
        zeros_seen += z;
        code_sr = '0;
        code_n  = '0;
        if (group_may_open()) begin
            push_sym(grp, zcgd_pkg::LEN_GROUP, 1'b0, 3'd0);
        end else if (resid_zeros == 0 || zeros_seen >= tgt_zeros) begin
            push_sym(grp, zcgd_pkg::LEN_GROUP, 1'b1, 3'd0);
            restart_block();
        end else begin
            push_sym(grp, zcgd_pkg::LEN_GROUP, 1'b0, 3'd0);
            dec_phase = zcgd_pkg::PH_RAW;
        end
    endtask

    // ------------------------------------------------------------------
    // Input side: predict on every accepted item, drive at the falling edge
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            decode_code_bit(s_code_bit);
            bit_taken = 1'b1;
            bits_accepted++;
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !bit_taken) begin
            // hold the item until it is accepted
        end else begin
            bit_taken = 1'b0;
            if (src_gap > 0) begin
                s_valid <= 1'b0;
                src_gap--;
            end else if (code_bits_q.size() > 0) begin
                s_valid    <= 1'b1;
                s_code_bit <= code_bits_q.pop_front();
                // open an idle burst after this item now and then
                if (!calm && $urandom_range(0, 9) == 0)
                    src_gap = $urandom_range(1, 7);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result side: stall in bursts, plus one long hold-off to back up the block
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            m_ready <= 1'b0;
            hold_cycles--;
        end else if (!long_hold_done && bits_accepted >= 30) begin
            // hold off long enough for the block to stall its input
            long_hold_done = 1'b1;
            hold_cycles    = 59;
            m_ready       <= 1'b0;
        end else if (sink_gap > 0) begin
            m_ready <= 1'b0;
            sink_gap--;
        end else begin
            m_ready <= 1'b1;
            if (!calm && $urandom_range(0, 7) == 0)
                sink_gap = $urandom_range(1, 7);
        end
    end

    // Compare every accepted result with the oldest prediction
    always @(posedge aclk) begin
        zcgd_pkg::res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_syms.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: val=%0d len=%0d last=%0b unc=%0d",
                             m_sym_value, m_sym_len, m_last, m_unconsumed_bits);
            end else begin
                want = expected_syms.pop_front();
                if (m_sym_value !== want.val || m_sym_len !== want.len ||
                    m_last !== want.last || m_unconsumed_bits !== want.unc) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected val=%0d len=%0d last=%0b unc=%0d, ",
                                 want.val, want.len, want.last, want.unc,
                                 "got val=%0d len=%0d last=%0b unc=%0d",
                                 m_sym_value, m_sym_len, m_last, m_unconsumed_bits);
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("zero_count_group_decoder_top regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequencing
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [zcgd_pkg::CfgIdxW-1:0] idx,
                             input logic [zcgd_pkg::CfgDataW-1:0] val);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            zcgd_pkg::CFG_TARGET_ZEROS:   tgt_zeros   = val[15:0];
            zcgd_pkg::CFG_RESIDUAL_COUNT: resid_zeros = val[7:0];
            zcgd_pkg::CFG_BIT_BUDGET:     budget_bits = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_regs(input int unsigned tz, input int unsigned rc, input int unsigned bb);
        write_reg(zcgd_pkg::CFG_TARGET_ZEROS, tz[zcgd_pkg::CfgDataW-1:0]);
        write_reg(zcgd_pkg::CFG_RESIDUAL_COUNT, rc[zcgd_pkg::CfgDataW-1:0]);
        write_reg(zcgd_pkg::CFG_BIT_BUDGET, bb[zcgd_pkg::CfgDataW-1:0]);
    endtask

    // Wait until every item went in and every result came out, then settle
    task automatic wait_drained();
        do @(posedge aclk);
        while (code_bits_q.size() > 0 || s_valid || expected_syms.size() > 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic push_code(input logic [3:0] code, input int unsigned n);
        int unsigned i;
        for (i = 0; i < n; i++)
            code_bits_q.push_back(code[n - 1 - i]);
    endtask

    initial begin
        int unsigned k, j, p0, tz, rc, bb;
        tgt_zeros   = '0;
        resid_zeros = '0;
        budget_bits = '0;
        restart_block();

        // Hold reset low, then release it at a falling edge
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Reset settings: no room for a group, the bit comes back on a marker
        code_bits_q.push_back(1'b1);
        wait_drained();

        // Every code word once, with room to spare
        set_regs(20, 0, 20'hFFFFF);
        push_code(4'b0000, 2);
        push_code(4'b0010, 3);
        push_code(4'b0011, 3);
        push_code(4'b0100, 3);
        push_code(4'b0101, 3);
        push_code(4'b0110, 3);
        push_code(4'b1110, 4);
        push_code(4'b1111, 4);
        wait_drained();

        // Random phases; the first three use fixed corner settings
        for (k = 0; k < 10; k++) begin
            case (k)
                0: begin tz = 65535; rc = 255; bb = 0;       end
                1: begin tz = 0;     rc = 0;   bb = 20'hFFFFF; end
                2: begin tz = 6;     rc = 255; bb = 20'hFFFFF; end
                default: begin
                    tz = $urandom_range(1, 14);
                    rc = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 4);
                    case ($urandom_range(0, 3))
                        0: bb = $urandom_range(0, 12);
                        1: bb = $urandom_range(0, 40);
                        2: bb = 20'hFFFFF;
                        default: bb = $urandom_range(0, 20'hFFFFF);
                    endcase
                end
            endcase
            // drop idling in the last stretch of the run
            if (k >= 8)
                calm = 1'b1;
            set_regs(tz, rc, bb);
            p0 = $urandom_range(20, 80);
            for (j = 0; j < 15; j++)
                code_bits_q.push_back($urandom_range(1, 100) > p0);
            wait_drained();
        end

        if (mismatches == 0) begin
            $display("zero_count_group_decoder_top regression: pass");
        end else begin
            $display("zero_count_group_decoder_top regression: fail");
        end
        $finish;
    end

endmodule
